FILE: sv/key_repeat_generator_unit_macros.svh
// Assertion macros shared by the key repeat generator RTL.
// Depends on nothing; the bodies compile to nothing when SYNTHESIS is set.
`ifndef KEY_REPEAT_GENERATOR_UNIT_MACROS_SVH
`define KEY_REPEAT_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent checked at the same edge as the antecedent.
`define KRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent.
`define KRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KRG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define KRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/krg_pkg.sv
// Shared types and codes for the key repeat generator.
// Used by every module of the block; depends on nothing.
package krg_pkg;

  localparam int KEY_W     = 10;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 1'b1;

  // Command codes.
  localparam logic CMD_EDGE      = 1'b0;
  localparam logic CMD_TYPEMATIC = 1'b1;

  // Decision of the update logic for one sample.
  typedef struct packed {
    logic fire;   // report a press or repeat
    logic write;  // the table entry changes
  } krg_upd_t;

endpackage

FILE: sv/key_repeat_generator_unit.sv
// Top level of the key repeat generator: configuration registers, sample stage
// and result register. Depends on krg_pkg, krg_store, krg_update and the macros.
//
// Usage. A key sample (in_cmd, in_key_index, in_key_down, in_timestamp) is
// transferred at a rising edge with start high and busy low. Every transfer
// gives exactly one result: out_valid is high for one cycle with out_fire and
// out_range_error on the result ports, and the receiver cannot hold it off.
// A transferred sample passes through the sample stage and then the result
// register. While busy is low a new sample may follow in every cycle, so the
// sustained rate is one sample per cycle, set by the single read-modify-write
// of the key table; a sample that hits the key written in the cycle before
// picks up the new entry through the table's bypass.
// After reset the key table is swept to zero, one entry a cycle, over all KEY_COUNT
// entries (512 by default). busy stays high through that sweep and no sample
// is taken; configuration writes are taken at any time. Configuration is a
// plain write port: cfg_we, cfg_index and cfg_data. Registers reset to warm-up
// 500 ticks and repeat 50 ticks. A key index at or above KEY_COUNT reports
// range_error with no fire and leaves the table.
`include "key_repeat_generator_unit_macros.svh"

module key_repeat_generator_unit #(
  parameter int KEY_COUNT = 512,
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_cmd,
  input  logic [krg_pkg::KEY_W-1:0]        in_key_index,
  input  logic                             in_key_down,
  input  logic [31:0]                      in_timestamp,
  output logic                             out_valid,
  output logic                             out_fire,
  output logic                             out_range_error,
  input  logic                             cfg_we,
  input  logic [krg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [krg_pkg::CFG_W-1:0]        cfg_data
);
  import krg_pkg::*;

  localparam int AW = $clog2(KEY_COUNT);
  localparam int EW = TIME_BITS + 2;
  localparam int TW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Configuration registers.
  logic [CFG_W-1:0] warmup_r;
  logic [CFG_W-1:0] repeat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r <= CFG_W'(500);
      repeat_r <= CFG_W'(50);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WARMUP: warmup_r <= cfg_data;
        CFG_REPEAT: repeat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input transfer and range check.
  logic                 accept;
  logic                 in_range;
  logic                 clearing;
  logic [TW-1:0]        ts_ext;

  assign busy     = clearing;
  assign accept   = start && !busy;
  assign in_range = (KEY_W + 1)'(in_key_index) < (KEY_W + 1)'(KEY_COUNT);
  assign ts_ext   = TW'(in_timestamp);

  // Sample stage: the table read for this sample lands alongside it.
  logic                 s1_valid_r;
  logic                 s1_err_r;
  logic                 s1_cmd_r;
  logic                 s1_down_r;
  logic [AW-1:0]        s1_addr_r;
  logic [TIME_BITS-1:0] s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r  <= !in_range;
      s1_cmd_r  <= in_cmd;
      s1_down_r <= in_key_down;
      s1_addr_r <= in_key_index[AW-1:0];
      s1_now_r  <= ts_ext[TIME_BITS-1:0];
    end
  end

  logic [EW-1:0] rd_entry;
  logic [EW-1:0] entry_nxt;
  krg_upd_t      upd;
  logic          wr_en;

  assign wr_en = s1_valid_r && !s1_err_r && upd.write;

  krg_store #(
    .KEY_COUNT (KEY_COUNT),
    .EW        (EW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept && in_range),
    .rd_addr  (in_key_index[AW-1:0]),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr_r),
    .wr_data  (entry_nxt),
    .rd_data  (rd_entry),
    .clearing (clearing)
  );

  krg_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .cmd          (s1_cmd_r),
    .key_down     (s1_down_r),
    .now          (s1_now_r),
    .entry        (rd_entry),
    .warmup_ticks (warmup_r),
    .repeat_ticks (repeat_r),
    .entry_nxt    (entry_nxt),
    .upd          (upd)
  );

  // Result register: one strobe per transferred sample.
  logic out_valid_r;
  logic out_fire_r;
  logic out_range_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_fire_r        <= !s1_err_r && upd.fire;
      out_range_error_r <= s1_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fire        = out_fire_r;
  assign out_range_error = out_range_error_r;

  `KRG_ASSERT_SAME(a_result_has_sample, clk, rst_n, out_valid, $past(start && !busy, 2), "result without transfer")
  `KRG_ASSERT_SAME(a_error_no_fire, clk, rst_n, out_valid && out_range_error, !out_fire, "fire on bad key")
  `KRG_ASSERT_SAME(a_no_write_on_error, clk, rst_n, s1_valid_r && s1_err_r, !wr_en, "table written on bad key")

endmodule

FILE: sv/krg_store.sv
// Per-key state table: one write port, one registered read port, write-first bypass
// and a clearing sweep after reset. Depends on krg_pkg and the assertion macros.
`include "key_repeat_generator_unit_macros.svh"

module krg_store #(
  parameter int KEY_COUNT = 512,
  parameter int EW        = 34
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(KEY_COUNT)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(KEY_COUNT)-1:0] wr_addr,
  input  logic [EW-1:0]                wr_data,
  output logic [EW-1:0]                rd_data,
  output logic                         clearing
);
  import krg_pkg::*;

  localparam int AW = $clog2(KEY_COUNT);

  logic [EW-1:0] mem [KEY_COUNT];
  logic [EW-1:0] rd_data_r;
  logic          clr_active_r;
  logic [AW-1:0] clr_cnt_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(KEY_COUNT - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // A read that meets a write to the same entry returns the new data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

  `KRG_ASSERT_SAME(a_no_read_in_clear, clk, rst_n, rd_en, !clr_active_r, "read during clear")
  `KRG_ASSERT_SAME(a_no_write_in_clear, clk, rst_n, wr_en, !clr_active_r, "write during clear")
  `KRG_ASSERT_NEXT(a_clear_done_stays, clk, rst_n, !clr_active_r, !clr_active_r, "clear restarted")

endmodule

FILE: sv/krg_update.sv
// Next-entry and fire decision for one sampled key.
// Purely combinational; depends on krg_pkg.
module krg_update #(
  parameter int TIME_BITS = 32
) (
  input  logic                   cmd,
  input  logic                   key_down,
  input  logic [TIME_BITS-1:0]   now,
  input  logic [TIME_BITS+1:0]   entry,
  input  logic [krg_pkg::CFG_W-1:0] warmup_ticks,
  input  logic [krg_pkg::CFG_W-1:0] repeat_ticks,
  output logic [TIME_BITS+1:0]   entry_nxt,
  output krg_pkg::krg_upd_t      upd
);
  import krg_pkg::*;

  // Compare width covers both the time and the register at full width.
  localparam int CW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic                 released;
  logic                 warmed;
  logic [TIME_BITS-1:0] last;
  logic [TIME_BITS-1:0] elapsed;
  logic [CFG_W-1:0]     limit;
  logic                 expired;

  assign released = entry[TIME_BITS+1];
  assign warmed   = entry[TIME_BITS];
  assign last     = entry[TIME_BITS-1:0];
  assign elapsed  = now - last;
  assign limit    = warmed ? repeat_ticks : warmup_ticks;
  assign expired  = CW'(elapsed) > CW'(limit);

  always_comb begin
    entry_nxt = entry;
    upd.fire  = 1'b0;
    upd.write = 1'b0;
    if (!key_down) begin
      entry_nxt[TIME_BITS+1] = 1'b1;
      upd.write = 1'b1;
    end else if (released) begin
      entry_nxt[TIME_BITS+1] = 1'b0;
      upd.fire  = 1'b1;
      upd.write = 1'b1;
      if (cmd == CMD_TYPEMATIC) begin
        entry_nxt[TIME_BITS]     = 1'b0;
        entry_nxt[TIME_BITS-1:0] = now;
      end
    end else if ((cmd == CMD_TYPEMATIC) && expired) begin
      entry_nxt[TIME_BITS]     = 1'b1;
      entry_nxt[TIME_BITS-1:0] = now;
      upd.fire  = 1'b1;
      upd.write = 1'b1;
    end
  end

endmodule
